FILE: src/cse_pkg.sv
// package for the counting semaphore engine: sizes, codes and item types
`timescale 1ns / 1ps

package cse_pkg;

  // table sizes
  localparam int NUM_SEMS   = 16;
  localparam int WAIT_DEPTH = 8;

  // derived widths
  localparam int SEM_W    = $clog2(NUM_SEMS);
  localparam int PFILL_W  = $clog2(NUM_SEMS + 1);
  localparam int WQ_W     = $clog2(WAIT_DEPTH);
  localparam int FILL_W   = $clog2(WAIT_DEPTH + 1);
  localparam int WADDR_W  = $clog2(NUM_SEMS * WAIT_DEPTH);

  // item field widths
  localparam int ID_W     = 4;
  localparam int COUNT_W  = 16;
  localparam int PID_W    = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_DESTROY = 2'd1,
    OP_WAIT    = 2'd2,
    OP_POST    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_ERROR   = 2'd1,
    STAT_BLOCKED = 2'd2,
    STAT_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t            opcode;
    logic [ID_W-1:0]    sem_id;
    logic [COUNT_W-1:0] init_value;
    logic [PID_W-1:0]   requester;
  } req_item_t;

  typedef struct packed {
    status_t            status;
    logic [COUNT_W-1:0] result_value;
    logic               woken_valid;
    logic [PID_W-1:0]   woken_requester;
  } rsp_item_t;

endpackage

FILE: src/counting_semaphore_engine.sv
// top level of the counting semaphore engine: semaphore table and request sequencer
`timescale 1ns / 1ps

// usage
//   requests enter on req_valid / req_ready / req_item, one item at a time;
//   each item yields exactly one result on rsp_valid / rsp_ready / rsp_item
//   opcodes: allocate, destroy, wait, post (see cse_pkg for codes)
// timing
//   req_ready is high only while the sequencer is idle
//   most items: accepted in the idle state, decided in the exec state and
//   loaded into the output register when it is free; a new item is taken
//   only once the sequencer is back in the idle state
//   a post that releases a waiter also passes through the wake state, since
//   the waiter ram has a registered read port
// stall
//   the result register holds its item until rsp_ready; the sequencer can
//   take the next request meanwhile but will not finish it until the
//   result register is free
// reset
//   synchronous, active high: the free pool is refilled with every id in
//   order, all semaphores are unallocated with zero count and empty queues;
//   the waiter ram is not cleared, its slots are only read after being written

module counting_semaphore_engine
  import cse_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_item_t req_item,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp_item
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WAKE
  } state_t;

  state_t state;

  // captured request
  req_item_t item;

  // free id pool, a ring of ids
  logic [SEM_W-1:0]   pool [NUM_SEMS];
  logic [SEM_W-1:0]   pool_head;
  logic [PFILL_W-1:0] pool_fill;

  // per-semaphore table
  logic               allocated [NUM_SEMS];
  logic [COUNT_W-1:0] sem_count [NUM_SEMS];
  logic [WQ_W-1:0]    wq_head   [NUM_SEMS];
  logic [FILL_W-1:0]  wq_fill   [NUM_SEMS];

  // lookups for the current item
  logic [SEM_W-1:0]   cur_idx;
  logic               bad_id;
  logic               cur_alloc;
  logic [COUNT_W-1:0] cur_count;
  logic [WQ_W-1:0]    cur_head;
  logic [FILL_W-1:0]  cur_fill;
  logic [WQ_W:0]      wpos_sum;
  logic [WQ_W-1:0]    wpos;
  logic [SEM_W:0]     ptail_sum;
  logic [SEM_W-1:0]   ptail;
  logic [SEM_W-1:0]   nid;
  logic [WADDR_W-1:0] wq_base;

  // decision of the exec step
  rsp_item_t res;
  logic      do_alloc;
  logic      do_destroy;
  logic      do_dec;
  logic      do_inc;
  logic      do_block;
  logic      post_wake;
  logic      go;
  logic      rsp_load;

  // waiter ram ports
  logic               ram_we;
  logic               ram_re;
  logic [WADDR_W-1:0] ram_waddr;
  logic [WADDR_W-1:0] ram_raddr;
  logic [PID_W-1:0]   ram_rdata;

  cse_ram #(
    .WIDTH (PID_W),
    .DEPTH (NUM_SEMS * WAIT_DEPTH)
  ) u_waiters (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (item.requester),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign req_ready = (state == S_IDLE);
  // the result register is free, or frees up at this edge
  assign go = !rsp_valid || rsp_ready;

  always_comb begin
    cur_idx   = SEM_W'(item.sem_id);
    bad_id    = (32'(item.sem_id) >= NUM_SEMS);
    cur_alloc = allocated[cur_idx];
    cur_count = sem_count[cur_idx];
    cur_head  = wq_head[cur_idx];
    cur_fill  = wq_fill[cur_idx];

    // tail slot of this semaphore's wait ring
    wpos_sum = {1'b0, cur_head} + (WQ_W+1)'(cur_fill);
    if (32'(wpos_sum) >= WAIT_DEPTH) begin
      wpos_sum = wpos_sum - (WQ_W+1)'(WAIT_DEPTH);
    end
    wpos = WQ_W'(wpos_sum);

    // tail slot of the free pool
    ptail_sum = {1'b0, pool_head} + (SEM_W+1)'(pool_fill);
    if (32'(ptail_sum) >= NUM_SEMS) begin
      ptail_sum = ptail_sum - (SEM_W+1)'(NUM_SEMS);
    end
    ptail = SEM_W'(ptail_sum);

    nid       = pool[pool_head];
    wq_base   = WADDR_W'(cur_idx) * WADDR_W'(WAIT_DEPTH);
    ram_waddr = wq_base + WADDR_W'(wpos);
    ram_raddr = wq_base + WADDR_W'(cur_head);
  end

  always_comb begin
    res.status          = STAT_DONE;
    res.result_value    = '0;
    res.woken_valid     = 1'b0;
    res.woken_requester = '0;
    do_alloc   = 1'b0;
    do_destroy = 1'b0;
    do_dec     = 1'b0;
    do_inc     = 1'b0;
    do_block   = 1'b0;
    post_wake  = 1'b0;

    if (item.opcode == OP_ALLOC) begin
      if (pool_fill == '0) begin
        res.status = STAT_ERROR;
      end else begin
        do_alloc         = 1'b1;
        res.result_value = COUNT_W'(nid);
      end
    end else if (bad_id) begin
      res.status = STAT_ERROR;
    end else if (!cur_alloc) begin
      res.status       = STAT_ERROR;
      res.result_value = cur_count;
    end else begin
      unique case (item.opcode)
        OP_DESTROY: begin
          if (cur_fill != '0) begin
            res.status       = STAT_ERROR;
            res.result_value = cur_count;
          end else begin
            do_destroy = 1'b1;
          end
        end
        OP_WAIT: begin
          if (cur_count != '0) begin
            do_dec           = 1'b1;
            res.result_value = cur_count - 1'b1;
          end else if (32'(cur_fill) >= WAIT_DEPTH) begin
            res.status = STAT_FULL;
          end else begin
            do_block   = 1'b1;
            res.status = STAT_BLOCKED;
          end
        end
        OP_POST: begin
          if (cur_fill != '0) begin
            post_wake = 1'b1;
          end else if (cur_count == COUNT_MAX) begin
            res.status       = STAT_FULL;
            res.result_value = COUNT_MAX;
          end else begin
            do_inc           = 1'b1;
            res.result_value = cur_count + 1'b1;
          end
        end
        OP_ALLOC: begin
          res.status = STAT_ERROR;
        end
      endcase
    end

    // queue the blocked requester once the result can be delivered
    ram_we = (state == S_EXEC) && do_block && go;
    // fetch the oldest waiter; the data is used in the wake step
    ram_re = (state == S_EXEC) && post_wake;
    // a result is loaded into the output register at this edge
    rsp_load = go && (((state == S_EXEC) && !post_wake) || (state == S_WAKE));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      pool_head <= '0;
      pool_fill <= PFILL_W'(NUM_SEMS);
      for (int i = 0; i < NUM_SEMS; i++) begin
        pool[i]      <= SEM_W'(i);
        allocated[i] <= 1'b0;
        sem_count[i] <= '0;
        wq_head[i]   <= '0;
        wq_fill[i]   <= '0;
      end
    end else begin
      // a new result loaded at this edge keeps valid high
      if (rsp_valid && rsp_ready && !rsp_load) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            item  <= req_item;
            state <= S_EXEC;
          end
        end

        S_EXEC: begin
          if (post_wake) begin
            state <= S_WAKE;
          end else if (go) begin
            rsp_item  <= res;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;

            if (do_alloc) begin
              allocated[nid] <= 1'b1;
              sem_count[nid] <= item.init_value;
              wq_head[nid]   <= '0;
              wq_fill[nid]   <= '0;
              if (pool_head == SEM_W'(NUM_SEMS - 1)) begin
                pool_head <= '0;
              end else begin
                pool_head <= pool_head + 1'b1;
              end
              pool_fill <= pool_fill - 1'b1;
            end

            if (do_destroy) begin
              allocated[cur_idx] <= 1'b0;
              sem_count[cur_idx] <= '0;
              wq_head[cur_idx]   <= '0;
              wq_fill[cur_idx]   <= '0;
              // return the id to the pool unless it is already full
              if (32'(pool_fill) < NUM_SEMS) begin
                pool[ptail] <= cur_idx;
                pool_fill   <= pool_fill + 1'b1;
              end
            end

            if (do_dec) begin
              sem_count[cur_idx] <= cur_count - 1'b1;
            end
            if (do_inc) begin
              sem_count[cur_idx] <= cur_count + 1'b1;
            end
            if (do_block) begin
              wq_fill[cur_idx] <= cur_fill + 1'b1;
            end
          end
        end

        S_WAKE: begin
          // waiter released, count left as it was
          if (go) begin
            rsp_item.status          <= STAT_DONE;
            rsp_item.result_value    <= cur_count;
            rsp_item.woken_valid     <= 1'b1;
            rsp_item.woken_requester <= ram_rdata;
            rsp_valid                <= 1'b1;
            state                    <= S_IDLE;
            if (cur_head == WQ_W'(WAIT_DEPTH - 1)) begin
              wq_head[cur_idx] <= '0;
            end else begin
              wq_head[cur_idx] <= cur_head + 1'b1;
            end
            wq_fill[cur_idx] <= cur_fill - 1'b1;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: src/cse_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module cse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
